// ===== rtl/sfcs_pkg.sv =====
// ============================================================================
// SPI flash command sequencer package
// Shared transfer types, request codes, flash opcodes and configuration
// defaults.
// ============================================================================
package sfcs_pkg;

    localparam int unsigned PageBytesDef   = 256;
    localparam int unsigned BlockBytesDef  = 65536;
    localparam int unsigned AddressBitsDef = 24;
    localparam int unsigned MaxResults     = 8;
    localparam int unsigned ResCountBits   = 4;

    localparam logic [2:0] KIND_READ_ID   = 3'd0;
    localparam logic [2:0] KIND_READ      = 3'd1;
    localparam logic [2:0] KIND_WRITE     = 3'd2;
    localparam logic [2:0] KIND_BLK_ERASE = 3'd3;
    localparam logic [2:0] KIND_CHP_ERASE = 3'd4;
    localparam logic [2:0] KIND_UNLOCK    = 3'd5;
    localparam logic [2:0] KIND_WR_BYTE   = 3'd6;
    localparam logic [2:0] KIND_REPLY     = 3'd7;

    localparam logic [7:0] OP_WREN = 8'h06;
    localparam logic [7:0] OP_PROG = 8'h02;
    localparam logic [7:0] OP_READ = 8'h03;
    localparam logic [7:0] OP_RDSR = 8'h05;
    localparam logic [7:0] OP_CE   = 8'hC7;
    localparam logic [7:0] OP_BE   = 8'hD8;
    localparam logic [7:0] OP_RDID = 8'h90;
    localparam logic [7:0] OP_RES  = 8'hAB;
    localparam logic [7:0] OP_WRSR = 8'h01;
    localparam logic [7:0] DUMMY   = 8'hFF;
    localparam logic [7:0] ZERO_B  = 8'h00;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_ID_HI  = 4'd1;
    localparam logic [3:0] PH_ID_LO  = 4'd2;
    localparam logic [3:0] PH_READ   = 4'd3;
    localparam logic [3:0] PH_WDATA  = 4'd4;
    localparam logic [3:0] PH_POLL   = 4'd5;
    localparam logic [3:0] PH_UNLOCK = 4'd6;

    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] address;
        logic [15:0] length;
        logic [7:0]  block_index;
        logic [7:0]  write_byte;
        logic [7:0]  reply_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic        frame_end;
        logic        reply_wanted;
        logic [7:0]  read_data;
        logic        read_valid;
        logic [15:0] flash_id;
        logic        id_valid;
        logic        op_done;
        logic        protocol_error;
        logic        last;
    } t_out_item;

    function automatic t_out_item f_bus(logic [7:0] b, logic fe, logic rw);
        t_out_item r;
        r = '0;
        r.tx_byte      = b;
        r.tx_valid     = 1'b1;
        r.frame_end    = fe;
        r.reply_wanted = rw;
        return r;
    endfunction

endpackage

// ===== rtl/sfcs_step.sv =====
// ============================================================================
// Sequencer step logic
// Works out, from the registered input transfer and the sequencer state, the
// burst of result transfers and the next state.
// ============================================================================
module sfcs_step #(
    parameter int unsigned PAGE_BYTES   = sfcs_pkg::PageBytesDef,
    parameter int unsigned BLOCK_BYTES  = sfcs_pkg::BlockBytesDef,
    parameter int unsigned ADDRESS_BITS = sfcs_pkg::AddressBitsDef
) (
    input  sfcs_pkg::t_in_item               i_item,
    input  logic [3:0]                       i_phase,
    input  logic [2:0]                       i_req,
    input  logic [ADDRESS_BITS-1:0]          i_addr,
    input  logic [15:0]                      i_left,
    input  logic [$clog2(PAGE_BYTES):0]      i_chunk,
    input  logic [7:0]                       i_id_hi,
    output logic [3:0]                       o_phase,
    output logic [2:0]                       o_req,
    output logic [ADDRESS_BITS-1:0]          o_addr,
    output logic [15:0]                      o_left,
    output logic [$clog2(PAGE_BYTES):0]      o_chunk,
    output logic [7:0]                       o_id_hi,
    output sfcs_pkg::t_out_item              o_res [sfcs_pkg::MaxResults],
    output logic [sfcs_pkg::ResCountBits-1:0] o_count
);
    localparam int unsigned PgBits = $clog2(PAGE_BYTES);
    localparam int unsigned BlkBits = $clog2(BLOCK_BYTES);
    localparam int unsigned CkW = PgBits + 1;
    localparam int unsigned ResCountBits = sfcs_pkg::ResCountBits;

    logic [23:0]       a24;
    logic [23:0]       blk_addr;
    logic [CkW-1:0]    chunk_new;
    logic [ADDRESS_BITS-1:0] addr_in;
    logic [ADDRESS_BITS-1:0] addr_inc;
    logic [15:0]       left_dec;
    logic [CkW-1:0]    chunk_dec;
    logic              ok;
    logic [23:0]       blk_wide;

    always_comb begin
        addr_in  = i_item.address[ADDRESS_BITS-1:0];
        addr_inc = i_addr + 1'b1;
        left_dec = (i_left != 16'd0) ? i_left - 16'd1 : i_left;
        chunk_dec = (i_chunk != '0) ? i_chunk - 1'b1 : i_chunk;
        blk_wide = 24'(i_item.block_index) << BlkBits;
        blk_addr = 24'(blk_wide[ADDRESS_BITS-1:0]);
    end

    // Chunk size for a chunk starting at address a with count n left.
    function automatic logic [CkW-1:0] f_chunk(logic [ADDRESS_BITS-1:0] a,
                                               logic [15:0] n);
        logic [CkW-1:0] rm;
        rm = CkW'(PAGE_BYTES) - CkW'(a[PgBits-1:0]);
        if (32'(n) < 32'(rm)) return CkW'(n);
        return rm;
    endfunction

    always_comb begin
        o_phase = i_phase;
        o_req   = i_req;
        o_addr  = i_addr;
        o_left  = i_left;
        o_chunk = i_chunk;
        o_id_hi = i_id_hi;
        for (int k = 0; k < sfcs_pkg::MaxResults; k++) o_res[k] = '0;
        o_count = '0;
        ok = 1'b1;
        a24 = 24'(i_addr);
        chunk_new = '0;
        if (i_phase == sfcs_pkg::PH_IDLE && i_item.kind <= sfcs_pkg::KIND_UNLOCK) begin
            o_req = i_item.kind;
            case (i_item.kind)
                sfcs_pkg::KIND_READ_ID: begin
                    o_res[0] = sfcs_pkg::f_bus(sfcs_pkg::OP_RDID, 1'b0, 1'b0);
                    o_res[1] = sfcs_pkg::f_bus(sfcs_pkg::ZERO_B, 1'b0, 1'b0);
                    o_res[2] = sfcs_pkg::f_bus(sfcs_pkg::ZERO_B, 1'b0, 1'b0);
                    o_res[3] = sfcs_pkg::f_bus(sfcs_pkg::ZERO_B, 1'b0, 1'b0);
                    o_res[4] = sfcs_pkg::f_bus(sfcs_pkg::DUMMY, 1'b0, 1'b1);
                    o_count = 4'd5;
                    o_phase = sfcs_pkg::PH_ID_HI;
                end
                sfcs_pkg::KIND_READ: begin
                    o_addr = addr_in;
                    o_left = i_item.length;
                    a24 = 24'(addr_in);
                    o_res[0] = sfcs_pkg::f_bus(sfcs_pkg::OP_READ, 1'b0, 1'b0);
                    o_res[1] = sfcs_pkg::f_bus(a24[23:16], 1'b0, 1'b0);
                    o_res[2] = sfcs_pkg::f_bus(a24[15:8], 1'b0, 1'b0);
                    if (i_item.length == 16'd0) begin
                        o_res[3] = sfcs_pkg::f_bus(a24[7:0], 1'b1, 1'b0);
                        o_res[3].op_done = 1'b1;
                        o_count = 4'd4;
                        o_phase = sfcs_pkg::PH_IDLE;
                    end else begin
                        o_res[3] = sfcs_pkg::f_bus(a24[7:0], 1'b0, 1'b0);
                        o_res[4] = sfcs_pkg::f_bus(sfcs_pkg::DUMMY,
                                                   i_item.length == 16'd1, 1'b1);
                        o_count = 4'd5;
                        o_phase = sfcs_pkg::PH_READ;
                    end
                end
                sfcs_pkg::KIND_WRITE: begin
                    o_addr = addr_in;
                    o_left = i_item.length;
                    a24 = 24'(addr_in);
                    if (i_item.length == 16'd0) begin
                        o_res[0].op_done = 1'b1;
                        o_count = 4'd1;
                        o_phase = sfcs_pkg::PH_IDLE;
                    end else begin
                        o_chunk = f_chunk(addr_in, i_item.length);
                        o_res[0] = sfcs_pkg::f_bus(sfcs_pkg::OP_WREN, 1'b1, 1'b0);
                        o_res[1] = sfcs_pkg::f_bus(sfcs_pkg::OP_PROG, 1'b0, 1'b0);
                        o_res[2] = sfcs_pkg::f_bus(a24[23:16], 1'b0, 1'b0);
                        o_res[3] = sfcs_pkg::f_bus(a24[15:8], 1'b0, 1'b0);
                        o_res[4] = sfcs_pkg::f_bus(a24[7:0], 1'b0, 1'b0);
                        o_count = 4'd5;
                        o_phase = sfcs_pkg::PH_WDATA;
                    end
                end
                sfcs_pkg::KIND_BLK_ERASE: begin
                    o_res[0] = sfcs_pkg::f_bus(sfcs_pkg::OP_WREN, 1'b1, 1'b0);
                    o_res[1] = sfcs_pkg::f_bus(sfcs_pkg::OP_BE, 1'b0, 1'b0);
                    o_res[2] = sfcs_pkg::f_bus(blk_addr[23:16], 1'b0, 1'b0);
                    o_res[3] = sfcs_pkg::f_bus(blk_addr[15:8], 1'b0, 1'b0);
                    o_res[4] = sfcs_pkg::f_bus(blk_addr[7:0], 1'b1, 1'b0);
                    o_res[5] = sfcs_pkg::f_bus(sfcs_pkg::OP_RDSR, 1'b0, 1'b0);
                    o_res[6] = sfcs_pkg::f_bus(sfcs_pkg::DUMMY, 1'b0, 1'b1);
                    o_count = 4'd7;
                    o_phase = sfcs_pkg::PH_POLL;
                end
                sfcs_pkg::KIND_CHP_ERASE: begin
                    o_res[0] = sfcs_pkg::f_bus(sfcs_pkg::OP_WREN, 1'b1, 1'b0);
                    o_res[1] = sfcs_pkg::f_bus(sfcs_pkg::OP_CE, 1'b1, 1'b0);
                    o_res[2] = sfcs_pkg::f_bus(sfcs_pkg::OP_RDSR, 1'b0, 1'b0);
                    o_res[3] = sfcs_pkg::f_bus(sfcs_pkg::DUMMY, 1'b0, 1'b1);
                    o_count = 4'd4;
                    o_phase = sfcs_pkg::PH_POLL;
                end
                default: begin
                    o_res[0] = sfcs_pkg::f_bus(sfcs_pkg::OP_RES, 1'b0, 1'b0);
                    o_res[1] = sfcs_pkg::f_bus(sfcs_pkg::ZERO_B, 1'b0, 1'b0);
                    o_res[2] = sfcs_pkg::f_bus(sfcs_pkg::ZERO_B, 1'b0, 1'b0);
                    o_res[3] = sfcs_pkg::f_bus(sfcs_pkg::ZERO_B, 1'b0, 1'b0);
                    o_res[4] = sfcs_pkg::f_bus(sfcs_pkg::DUMMY, 1'b1, 1'b1);
                    o_count = 4'd5;
                    o_phase = sfcs_pkg::PH_UNLOCK;
                end
            endcase
        end else if (i_phase == sfcs_pkg::PH_WDATA &&
                     i_item.kind == sfcs_pkg::KIND_WR_BYTE) begin
            o_res[0] = sfcs_pkg::f_bus(i_item.write_byte, i_chunk <= CkW'(1), 1'b0);
            o_chunk = chunk_dec;
            o_left = left_dec;
            o_addr = addr_inc;
            o_count = 4'd1;
            if (chunk_dec == '0) begin
                o_res[1] = sfcs_pkg::f_bus(sfcs_pkg::OP_RDSR, 1'b0, 1'b0);
                o_res[2] = sfcs_pkg::f_bus(sfcs_pkg::DUMMY, 1'b0, 1'b1);
                o_count = 4'd3;
                o_phase = sfcs_pkg::PH_POLL;
            end
        end else if (i_item.kind == sfcs_pkg::KIND_REPLY &&
                     i_phase != sfcs_pkg::PH_IDLE && i_phase != sfcs_pkg::PH_WDATA) begin
            case (i_phase)
                sfcs_pkg::PH_ID_HI: begin
                    o_id_hi = i_item.reply_byte;
                    o_res[0] = sfcs_pkg::f_bus(sfcs_pkg::DUMMY, 1'b1, 1'b1);
                    o_count = 4'd1;
                    o_phase = sfcs_pkg::PH_ID_LO;
                end
                sfcs_pkg::PH_ID_LO: begin
                    o_res[0].flash_id = {i_id_hi, i_item.reply_byte};
                    o_res[0].id_valid = 1'b1;
                    o_res[0].op_done = 1'b1;
                    o_count = 4'd1;
                    o_phase = sfcs_pkg::PH_IDLE;
                end
                sfcs_pkg::PH_READ: begin
                    o_left = left_dec;
                    o_addr = addr_inc;
                    if (left_dec != 16'd0) begin
                        o_res[0] = sfcs_pkg::f_bus(sfcs_pkg::DUMMY,
                                                   left_dec == 16'd1, 1'b1);
                    end else begin
                        o_res[0].op_done = 1'b1;
                        o_phase = sfcs_pkg::PH_IDLE;
                    end
                    o_res[0].read_data = i_item.reply_byte;
                    o_res[0].read_valid = 1'b1;
                    o_count = 4'd1;
                end
                sfcs_pkg::PH_POLL: begin
                    if (i_item.reply_byte[0]) begin
                        o_res[0] = sfcs_pkg::f_bus(sfcs_pkg::DUMMY, 1'b0, 1'b1);
                        o_count = 4'd1;
                    end else begin
                        o_res[0].frame_end = 1'b1;
                        if (i_req == sfcs_pkg::KIND_WRITE && i_left != 16'd0) begin
                            chunk_new = f_chunk(i_addr, i_left);
                            o_chunk = chunk_new;
                            o_res[1] = sfcs_pkg::f_bus(sfcs_pkg::OP_WREN, 1'b1, 1'b0);
                            o_res[2] = sfcs_pkg::f_bus(sfcs_pkg::OP_PROG, 1'b0, 1'b0);
                            o_res[3] = sfcs_pkg::f_bus(a24[23:16], 1'b0, 1'b0);
                            o_res[4] = sfcs_pkg::f_bus(a24[15:8], 1'b0, 1'b0);
                            o_res[5] = sfcs_pkg::f_bus(a24[7:0], 1'b0, 1'b0);
                            o_count = 4'd6;
                            o_phase = sfcs_pkg::PH_WDATA;
                        end else begin
                            o_res[0].op_done = 1'b1;
                            o_count = 4'd1;
                            o_phase = sfcs_pkg::PH_IDLE;
                        end
                    end
                end
                sfcs_pkg::PH_UNLOCK: begin
                    o_res[0] = sfcs_pkg::f_bus(sfcs_pkg::OP_WREN, 1'b1, 1'b0);
                    o_res[1] = sfcs_pkg::f_bus(sfcs_pkg::OP_WRSR, 1'b0, 1'b0);
                    o_res[2] = sfcs_pkg::f_bus(sfcs_pkg::ZERO_B, 1'b1, 1'b0);
                    o_res[2].flash_id = {8'd0, i_item.reply_byte};
                    o_res[2].id_valid = 1'b1;
                    o_res[2].op_done = 1'b1;
                    o_count = 4'd3;
                    o_phase = sfcs_pkg::PH_IDLE;
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
        end else begin
            ok = 1'b0;
        end
        if (!ok) begin
            o_phase = i_phase;
            o_req   = i_req;
            o_addr  = i_addr;
            o_left  = i_left;
            o_chunk = i_chunk;
            o_id_hi = i_id_hi;
            for (int k = 0; k < sfcs_pkg::MaxResults; k++) o_res[k] = '0;
            o_res[0].protocol_error = 1'b1;
            o_count = 4'd1;
        end
        for (int k = 0; k < sfcs_pkg::MaxResults; k++) begin
            if (ResCountBits'(k + 1) == o_count) o_res[k].last = 1'b1;
        end
    end

endmodule

// ===== rtl/spi_flash_command_sequencer.sv =====
// ============================================================================
// SPI flash command sequencer
// Turns flash requests into serial NOR flash byte frames, one result
// transfer per bus byte, with write chunking and busy polling.
// ============================================================================
// An accepted input waits in the input register and is expanded into the
// result buffer once that buffer has drained. Each input yields one to
// seven results, one per cycle while the output is ready; inputs with a
// single result flow back to back at one per cycle. The next input waits
// in the input register while a burst drains. Reset (synchronous, active
// low) returns the sequencer to idle and empties the result buffer.
module spi_flash_command_sequencer #(
    parameter int unsigned PAGE_BYTES   = sfcs_pkg::PageBytesDef,
    parameter int unsigned BLOCK_BYTES  = sfcs_pkg::BlockBytesDef,
    parameter int unsigned ADDRESS_BITS = sfcs_pkg::AddressBitsDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sfcs_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output sfcs_pkg::t_out_item o_item
);
    localparam int unsigned CkW = $clog2(PAGE_BYTES) + 1;
    localparam int unsigned Cw  = sfcs_pkg::ResCountBits;

    // Sequencer state.
    logic [3:0]              r_phase, n_phase;
    logic [2:0]              r_req, n_req;
    logic [ADDRESS_BITS-1:0] r_addr, n_addr;
    logic [15:0]             r_left, n_left;
    logic [CkW-1:0]          r_chunk, n_chunk;
    logic [7:0]              r_id_hi, n_id_hi;

    // Input register: an accepted transfer is held here until the result
    // buffer drains, and is then expanded into the result buffer.
    logic                    r_in_vld;
    sfcs_pkg::t_in_item      r_in;

    // Result buffer: one input's burst, one result per cycle while i_ready.
    sfcs_pkg::t_out_item     r_buf [sfcs_pkg::MaxResults];
    sfcs_pkg::t_out_item     n_buf [sfcs_pkg::MaxResults];
    logic [Cw-1:0]           r_cnt, n_cnt;
    logic [Cw-1:0]           r_pos;

    logic                    out_fire;
    logic                    drained;

    sfcs_step #(
        .PAGE_BYTES  (PAGE_BYTES),
        .BLOCK_BYTES (BLOCK_BYTES),
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_step (
        .i_item (r_in),
        .i_phase(r_phase),
        .i_req  (r_req),
        .i_addr (r_addr),
        .i_left (r_left),
        .i_chunk(r_chunk),
        .i_id_hi(r_id_hi),
        .o_phase(n_phase),
        .o_req  (n_req),
        .o_addr (n_addr),
        .o_left (n_left),
        .o_chunk(n_chunk),
        .o_id_hi(n_id_hi),
        .o_res  (n_buf),
        .o_count(n_cnt)
    );

    assign o_valid  = (r_cnt != '0);
    assign o_item   = r_buf[r_pos[2:0]];
    assign out_fire = o_valid && i_ready;
    // The buffer is free once it is empty or its final result leaves now.
    assign drained  = (r_cnt == '0) || (out_fire && (r_pos + 1'b1 == r_cnt));
    // An input may enter while the previous burst still drains, as long as
    // the input register will be free when the buffer frees.
    assign o_ready  = !r_in_vld || drained;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sfcs_pkg::PH_IDLE;
            r_req    <= '0;
            r_addr   <= '0;
            r_left   <= '0;
            r_chunk  <= '0;
            r_id_hi  <= '0;
            r_in_vld <= 1'b0;
            r_cnt    <= '0;
            r_pos    <= '0;
        end else begin
            if (drained) begin
                if (r_in_vld) begin
                    r_phase <= n_phase;
                    r_req   <= n_req;
                    r_addr  <= n_addr;
                    r_left  <= n_left;
                    r_chunk <= n_chunk;
                    r_id_hi <= n_id_hi;
                    r_buf   <= n_buf;
                    r_cnt   <= n_cnt;
                end else begin
                    r_cnt <= '0;
                end
                r_pos <= '0;
            end else if (out_fire) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_valid && o_ready) begin
                r_in_vld <= 1'b1;
                r_in     <= i_item;
            end else if (drained) begin
                r_in_vld <= 1'b0;
            end
        end
    end

    // A result is never offered beyond the end of its burst.
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_pos < r_cnt))
        else $error("result position beyond burst");

    // Only the final result of a burst carries the last marker.
    a_last_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.last == (r_pos + 1'b1 == r_cnt)))
        else $error("last marker misplaced");

    // A protocol error never moves the sequencer out of its phase.
    a_err_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (drained && r_in_vld && n_buf[0].protocol_error) |=> (r_phase == $past(r_phase)))
        else $error("phase changed on protocol error");

endmodule
